[sv/ftgc_pkg.sv]
// Shared constants, register indexes and types of the force-torque gravity compensation unit.
// Used by ftgc_cfg_regs and ft_sensor_gravity_compensation_unit; depends on nothing else.
package ftgc_pkg;

  localparam int COMP_BITS     = 20;
  localparam int ROT_FRAC_BITS = 16;
  localparam int ROT_BITS      = ROT_FRAC_BITS + 2;
  localparam int ROW_W         = 3 * ROT_BITS;
  localparam int VEC_W         = 3 * COMP_BITS;

  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 6;
  localparam int REG_IDX_LSB   = 3;

  // Datapath widths, all exact until the final clamp.
  localparam int PROD1_W = ROT_BITS + COMP_BITS;
  localparam int ACC1_W  = PROD1_W + 2;
  localparam int U_W     = ACC1_W - ROT_FRAC_BITS;
  localparam int PROD2_W = ROT_BITS + U_W;
  localparam int ACC2_W  = PROD2_W + 2;
  localparam int W_W     = ACC2_W - ROT_FRAC_BITS;
  localparam int D_W     = COMP_BITS + 1;
  localparam int CPROD_W = ROT_BITS + D_W;
  localparam int CX_W    = CPROD_W + 1;
  localparam int CXS_W   = CX_W - ROT_FRAC_BITS;
  localparam int SUM_W   = W_W + 1;

  localparam logic [ROW_W-1:0] ROT_ONE = ROW_W'(1) << ROT_FRAC_BITS;

  typedef enum logic [2:0] {
    REG_MOUNT_ROW_0   = 3'd0,
    REG_MOUNT_ROW_1   = 3'd1,
    REG_MOUNT_ROW_2   = 3'd2,
    REG_GRAVITY_FORCE = 3'd3,
    REG_MASS_CENTER   = 3'd4,
    REG_FORCE_OFFSET  = 3'd5,
    REG_TORQUE_OFFSET = 3'd6,
    REG_ENABLE        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][ROW_W-1:0] mount_row;
    logic [VEC_W-1:0]      gravity_force;
    logic [ROW_W-1:0]      mass_center;
    logic [VEC_W-1:0]      force_offset;
    logic [VEC_W-1:0]      torque_offset;
    logic                  enable;
  } cfg_t;

  typedef struct packed {
    logic [COMP_BITS-1:0] value;
    logic                 sat;
  } clamp_t;

  function automatic logic signed [ROT_BITS-1:0] rot_entry(input logic [ROW_W-1:0] word,
                                                           input int unsigned k);
    return $signed(word[k*ROT_BITS +: ROT_BITS]);
  endfunction

  function automatic logic signed [COMP_BITS-1:0] comp_entry(input logic [VEC_W-1:0] word,
                                                             input int unsigned k);
    return $signed(word[k*COMP_BITS +: COMP_BITS]);
  endfunction

  // The value fits when all bits from the component's sign bit upwards agree.
  function automatic clamp_t clamp_comp(input logic signed [SUM_W-1:0] v);
    clamp_t                       r;
    logic [SUM_W-COMP_BITS:0]     upper;
    upper   = v[SUM_W-1:COMP_BITS-1];
    r.sat   = !((&upper) || !(|upper));
    if (!r.sat) begin
      r.value = v[COMP_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      r.value = {1'b1, {(COMP_BITS-1){1'b0}}};
    end else begin
      r.value = {1'b0, {(COMP_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[sv/ft_sensor_gravity_compensation_unit.sv]
// Top level of the force-torque gravity compensation unit: four-stage datapath and handshakes.
// Depends on ftgc_pkg and ftgc_cfg_regs.
//
// The unit passes each force-torque word through the four register stages of the
// datapath (pose products, first rotation sum with the cross products, mounting
// products, final sums with clamping), and throughput is one word per cycle for as
// long as the sink does not stall. A stall on the output only holds back the input
// once every stage is occupied, so empty stages keep filling while a finished word
// waits. Configuration registers sit at byte addresses eight apart and should only
// be written while the pipeline is empty; with enable cleared words pass through
// unchanged.
module ft_sensor_gravity_compensation_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ftgc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ftgc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ftgc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ftgc_pkg::ROW_W-1:0]       pose_row_0_i,
  input  logic [ftgc_pkg::ROW_W-1:0]       pose_row_1_i,
  input  logic [ftgc_pkg::ROW_W-1:0]       pose_row_2_i,
  input  logic [ftgc_pkg::VEC_W-1:0]       measured_force_i,
  input  logic [ftgc_pkg::VEC_W-1:0]       measured_torque_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ftgc_pkg::VEC_W-1:0]       corrected_force_o,
  output logic [ftgc_pkg::VEC_W-1:0]       corrected_torque_o,
  output logic                             saturated_o
);
  import ftgc_pkg::*;

  cfg_t cfg;

  ftgc_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  // Pipeline control: a stage loads when it is empty or its successor moves on.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign ld1 = rdy1 && in_valid_i;
  assign ld2 = rdy2 && v1_q;
  assign ld3 = rdy3 && v2_q;
  assign ld4 = rdy4 && v3_q;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // Stage 1: pose products R[j][i] * g[j] and offset removal.
  logic [ROW_W-1:0]            pose [3];
  logic signed [PROD1_W-1:0]   p1_d [3][3];
  logic signed [PROD1_W-1:0]   p1_q [3][3];
  logic signed [D_W-1:0]       d1_d [3];
  logic signed [D_W-1:0]       d1_q [3];
  logic signed [D_W-1:0]       td1_d [3];
  logic signed [D_W-1:0]       td1_q [3];
  logic [VEC_W-1:0]            f1_q, t1_q;
  logic                        en1_q;

  assign pose[0] = pose_row_0_i;
  assign pose[1] = pose_row_1_i;
  assign pose[2] = pose_row_2_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p1_d[i][j] = rot_entry(pose[j], i) * comp_entry(cfg.gravity_force, j);
      end
      d1_d[i]  = D_W'(comp_entry(measured_force_i, i))
               - D_W'(comp_entry(cfg.force_offset, i));
      td1_d[i] = D_W'(comp_entry(measured_torque_i, i))
               - D_W'(comp_entry(cfg.torque_offset, i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      p1_q  <= p1_d;
      d1_q  <= d1_d;
      td1_q <= td1_d;
      f1_q  <= measured_force_i;
      t1_q  <= measured_torque_i;
      en1_q <= cfg.enable;
    end
  end

  // Stage 2: u = floor(R^T g) and the six cross-product terms of c x d.
  logic signed [ACC1_W-1:0]    acc1 [3];
  logic signed [U_W-1:0]       u2_d [3];
  logic signed [U_W-1:0]       u2_q [3];
  logic signed [ROT_BITS-1:0]  cm [3];
  logic signed [CPROD_W-1:0]   cp2_d [3][2];
  logic signed [CPROD_W-1:0]   cp2_q [3][2];
  logic signed [D_W-1:0]       d2_q [3];
  logic signed [D_W-1:0]       td2_q [3];
  logic [VEC_W-1:0]            f2_q, t2_q;
  logic                        en2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc1[i] = ACC1_W'(p1_q[i][0]) + ACC1_W'(p1_q[i][1]) + ACC1_W'(p1_q[i][2]);
      u2_d[i] = acc1[i][ACC1_W-1:ROT_FRAC_BITS];
      cm[i]   = rot_entry(cfg.mass_center, i);
    end
    cp2_d[0][0] = cm[1] * d1_q[2];
    cp2_d[0][1] = cm[2] * d1_q[1];
    cp2_d[1][0] = cm[2] * d1_q[0];
    cp2_d[1][1] = cm[0] * d1_q[2];
    cp2_d[2][0] = cm[0] * d1_q[1];
    cp2_d[2][1] = cm[1] * d1_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      u2_q  <= u2_d;
      cp2_q <= cp2_d;
      d2_q  <= d1_q;
      td2_q <= td1_q;
      f2_q  <= f1_q;
      t2_q  <= t1_q;
      en2_q <= en1_q;
    end
  end

  // Stage 3: mounting products M[j][i] * u[j] and the truncated cross product.
  logic signed [PROD2_W-1:0]   p3_d [3][3];
  logic signed [PROD2_W-1:0]   p3_q [3][3];
  logic signed [CX_W-1:0]      cx [3];
  logic signed [CXS_W-1:0]     cxs3_d [3];
  logic signed [CXS_W-1:0]     cxs3_q [3];
  logic signed [D_W-1:0]       d3_q [3];
  logic signed [D_W-1:0]       td3_q [3];
  logic [VEC_W-1:0]            f3_q, t3_q;
  logic                        en3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p3_d[i][j] = rot_entry(cfg.mount_row[j], i) * u2_q[j];
      end
      cx[i]     = CX_W'(cp2_q[i][0]) - CX_W'(cp2_q[i][1]);
      cxs3_d[i] = cx[i][CX_W-1:ROT_FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      p3_q   <= p3_d;
      cxs3_q <= cxs3_d;
      d3_q   <= d2_q;
      td3_q  <= td2_q;
      f3_q   <= f2_q;
      t3_q   <= t2_q;
      en3_q  <= en2_q;
    end
  end

  // Stage 4: w = floor(M^T u), final differences, clamping and packing, or pass-through when disabled.
  logic signed [ACC2_W-1:0]    acc2 [3];
  logic signed [W_W-1:0]       w [3];
  logic signed [SUM_W-1:0]     fsum [3];
  logic signed [SUM_W-1:0]     tsum [3];
  clamp_t                      fcl [3];
  clamp_t                      tcl [3];
  logic [VEC_W-1:0]            force_d, force_q;
  logic [VEC_W-1:0]            torque_d, torque_q;
  logic                        sat_d, sat_q;
  logic                        en4_q;

  always_comb begin
    force_d  = '0;
    torque_d = '0;
    sat_d    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc2[i] = ACC2_W'(p3_q[i][0]) + ACC2_W'(p3_q[i][1]) + ACC2_W'(p3_q[i][2]);
      w[i]    = acc2[i][ACC2_W-1:ROT_FRAC_BITS];
      fsum[i] = SUM_W'(d3_q[i]) - SUM_W'(w[i]);
      tsum[i] = SUM_W'(td3_q[i]) - SUM_W'(cxs3_q[i]);
      fcl[i]  = clamp_comp(fsum[i]);
      tcl[i]  = clamp_comp(tsum[i]);
      force_d[i*COMP_BITS +: COMP_BITS]  = fcl[i].value;
      torque_d[i*COMP_BITS +: COMP_BITS] = tcl[i].value;
      sat_d = sat_d || fcl[i].sat || tcl[i].sat;
    end
    if (!en3_q) begin
      force_d  = f3_q;
      torque_d = t3_q;
      sat_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      force_q  <= force_d;
      torque_q <= torque_d;
      sat_q    <= sat_d;
      en4_q    <= en3_q;
    end
  end

  assign out_valid_o        = v4_q;
  assign corrected_force_o  = force_q;
  assign corrected_torque_o = torque_q;
  assign saturated_o        = sat_q;

  // A word that passed through uncompensated never reports clamping.
  a_pass_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !en4_q) |-> !saturated_o)
    else $error("pass-through word flagged as saturated");

  // An empty first stage must always take a new word.
  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // With the output stalled and stages three and four full, stage three must hold its word.
  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v4_q && out_stall_i) |=> (v3_q && $stable(td3_q[0]) && $stable(en3_q)))
    else $error("stage three changed while blocked");

endmodule

[sv/ftgc_cfg_regs.sv]
// APB-style configuration register file of the gravity compensation unit.
// Depends on ftgc_pkg for the register indexes and the cfg_t bundle.
module ftgc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [ftgc_pkg::CFG_ADDR_W-1:0]  paddr_i,
  input  logic [ftgc_pkg::CFG_DATA_W-1:0]  pwdata_i,
  output logic [ftgc_pkg::CFG_DATA_W-1:0]  prdata_o,
  output ftgc_pkg::cfg_t                   cfg_o
);
  import ftgc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr_i[CFG_ADDR_W-1:REG_IDX_LSB]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MOUNT_ROW_0:   cfg_d.mount_row[0]  = pwdata_i[ROW_W-1:0];
        REG_MOUNT_ROW_1:   cfg_d.mount_row[1]  = pwdata_i[ROW_W-1:0];
        REG_MOUNT_ROW_2:   cfg_d.mount_row[2]  = pwdata_i[ROW_W-1:0];
        REG_GRAVITY_FORCE: cfg_d.gravity_force = pwdata_i[VEC_W-1:0];
        REG_MASS_CENTER:   cfg_d.mass_center   = pwdata_i[ROW_W-1:0];
        REG_FORCE_OFFSET:  cfg_d.force_offset  = pwdata_i[VEC_W-1:0];
        REG_TORQUE_OFFSET: cfg_d.torque_offset = pwdata_i[VEC_W-1:0];
        REG_ENABLE:        cfg_d.enable        = pwdata_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MOUNT_ROW_0:   prdata_o = CFG_DATA_W'(cfg_q.mount_row[0]);
      REG_MOUNT_ROW_1:   prdata_o = CFG_DATA_W'(cfg_q.mount_row[1]);
      REG_MOUNT_ROW_2:   prdata_o = CFG_DATA_W'(cfg_q.mount_row[2]);
      REG_GRAVITY_FORCE: prdata_o = CFG_DATA_W'(cfg_q.gravity_force);
      REG_MASS_CENTER:   prdata_o = CFG_DATA_W'(cfg_q.mass_center);
      REG_FORCE_OFFSET:  prdata_o = CFG_DATA_W'(cfg_q.force_offset);
      REG_TORQUE_OFFSET: prdata_o = CFG_DATA_W'(cfg_q.torque_offset);
      REG_ENABLE:        prdata_o = CFG_DATA_W'(cfg_q.enable);
      default:           prdata_o = '0;
    endcase
  end

  // The mounting rotation comes out of reset as the identity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mount_row[0]  <= ROT_ONE;
      cfg_q.mount_row[1]  <= ROT_ONE << ROT_BITS;
      cfg_q.mount_row[2]  <= ROT_ONE << (2 * ROT_BITS);
      cfg_q.gravity_force <= '0;
      cfg_q.mass_center   <= '0;
      cfg_q.force_offset  <= '0;
      cfg_q.torque_offset <= '0;
      cfg_q.enable        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the force-torque gravity compensation unit.
// Depends on ftgc_pkg and ft_sensor_gravity_compensation_unit; drives samples and APB writes,
// predicts each compensated word and compares it field by field.
`timescale 1ns / 100ps

module testbench;
  import ftgc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_SAMPLES  = 125;

  localparam logic [ROW_W-1:0]     ROW_X    = ROT_ONE;
  localparam logic [ROW_W-1:0]     ROW_Y    = ROT_ONE << ROT_BITS;
  localparam logic [ROW_W-1:0]     ROW_Z    = ROT_ONE << (2 * ROT_BITS);
  localparam logic [COMP_BITS-1:0] COMP_MAX = {1'b0, {(COMP_BITS-1){1'b1}}};
  localparam logic [COMP_BITS-1:0] COMP_MIN = {1'b1, {(COMP_BITS-1){1'b0}}};
  localparam logic [ROT_BITS-1:0]  ROT_MAX  = {1'b0, {(ROT_BITS-1){1'b1}}};
  localparam logic [ROT_BITS-1:0]  ROT_MIN  = {1'b1, {(ROT_BITS-1){1'b0}}};
  localparam logic [ROT_BITS-1:0]  ROT_HALF = ROT_BITS'(1) << (ROT_FRAC_BITS - 1);

  typedef struct packed {
    logic [ROW_W-1:0] pose_row_0;
    logic [ROW_W-1:0] pose_row_1;
    logic [ROW_W-1:0] pose_row_2;
    logic [VEC_W-1:0] meas_force;
    logic [VEC_W-1:0] meas_torque;
  } sample_t;

  typedef struct packed {
    logic [VEC_W-1:0] corr_force;
    logic [VEC_W-1:0] corr_torque;
    logic             saturated;
  } result_t;

  logic                  clk;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [ROW_W-1:0]      pose_row_0_i;
  logic [ROW_W-1:0]      pose_row_1_i;
  logic [ROW_W-1:0]      pose_row_2_i;
  logic [VEC_W-1:0]      measured_force_i;
  logic [VEC_W-1:0]      measured_torque_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [VEC_W-1:0]      corrected_force_o;
  logic [VEC_W-1:0]      corrected_torque_o;
  logic                  saturated_o;

  cfg_t    model_cfg;
  result_t expected_compensation[$];
  int      sender_idle_pct;
  int      sink_stall_pct;
  int      errors;
  int      samples_sent;
  int      results_checked;
  int      register_writes;
  int      quiet_cycles;

  ft_sensor_gravity_compensation_unit u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pose_row_0_i      (pose_row_0_i),
    .pose_row_1_i      (pose_row_1_i),
    .pose_row_2_i      (pose_row_2_i),
    .measured_force_i  (measured_force_i),
    .measured_torque_i (measured_torque_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .corrected_force_o (corrected_force_o),
    .corrected_torque_o(corrected_torque_o),
    .saturated_o       (saturated_o)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint rot_at(input logic [ROW_W-1:0] word, input int k);
    logic signed [ROT_BITS-1:0] e;
    e = word[k*ROT_BITS +: ROT_BITS];
    return longint'(e);
  endfunction

  function automatic longint comp_at(input logic [VEC_W-1:0] word, input int k);
    logic signed [COMP_BITS-1:0] e;
    e = word[k*COMP_BITS +: COMP_BITS];
    return longint'(e);
  endfunction

  function automatic logic [COMP_BITS-1:0] clamp_component(input longint v, inout bit clipped);
    longint hi;
    longint lo;
    hi = (longint'(1) << (COMP_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clipped = 1'b1;
      return hi[COMP_BITS-1:0];
    end
    if (v < lo) begin
      clipped = 1'b1;
      return lo[COMP_BITS-1:0];
    end
    return v[COMP_BITS-1:0];
  endfunction

  function automatic result_t predict_compensation(input sample_t s);
    logic [ROW_W-1:0]     pose[3];
    longint               grav[3], mc[3], dforce[3], dtorque[3], u[3], w[3], cxd[3];
    longint               acc;
    logic [COMP_BITS-1:0] fo[3], tq[3];
    bit                   clipped;
    result_t              r;
    if (!model_cfg.enable) begin
      r.corr_force  = s.meas_force;
      r.corr_torque = s.meas_torque;
      r.saturated   = 1'b0;
      return r;
    end
    pose[0] = s.pose_row_0;
    pose[1] = s.pose_row_1;
    pose[2] = s.pose_row_2;
    clipped = 1'b0;
    for (int k = 0; k < 3; k++) begin
      grav[k]    = comp_at(model_cfg.gravity_force, k);
      mc[k]      = rot_at(model_cfg.mass_center, k);
      dforce[k]  = comp_at(s.meas_force, k) - comp_at(model_cfg.force_offset, k);
      dtorque[k] = comp_at(s.meas_torque, k) - comp_at(model_cfg.torque_offset, k);
    end
    // Gravity into the flange frame, then through the transposed mounting rotation.
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rot_at(pose[j], i) * grav[j];
      u[i] = acc >>> ROT_FRAC_BITS;
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rot_at(model_cfg.mount_row[j], i) * u[j];
      w[i] = acc >>> ROT_FRAC_BITS;
    end
    cxd[0] = mc[1] * dforce[2] - mc[2] * dforce[1];
    cxd[1] = mc[2] * dforce[0] - mc[0] * dforce[2];
    cxd[2] = mc[0] * dforce[1] - mc[1] * dforce[0];
    for (int k = 0; k < 3; k++) begin
      fo[k] = clamp_component(dforce[k] - w[k], clipped);
      tq[k] = clamp_component(dtorque[k] - (cxd[k] >>> ROT_FRAC_BITS), clipped);
    end
    r.corr_force  = {fo[2], fo[1], fo[0]};
    r.corr_torque = {tq[2], tq[1], tq[0]};
    r.saturated   = clipped;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] shadow_reg(input reg_idx_e idx);
    case (idx)
      REG_MOUNT_ROW_0:   return CFG_DATA_W'(model_cfg.mount_row[0]);
      REG_MOUNT_ROW_1:   return CFG_DATA_W'(model_cfg.mount_row[1]);
      REG_MOUNT_ROW_2:   return CFG_DATA_W'(model_cfg.mount_row[2]);
      REG_GRAVITY_FORCE: return CFG_DATA_W'(model_cfg.gravity_force);
      REG_MASS_CENTER:   return CFG_DATA_W'(model_cfg.mass_center);
      REG_FORCE_OFFSET:  return CFG_DATA_W'(model_cfg.force_offset);
      REG_TORQUE_OFFSET: return CFG_DATA_W'(model_cfg.torque_offset);
      default:           return CFG_DATA_W'(model_cfg.enable);
    endcase
  endfunction

  // ---------------------------------------------------------------- value builders

  function automatic logic [ROW_W-1:0] row3(input logic [ROT_BITS-1:0] e0, e1, e2);
    return {e2, e1, e0};
  endfunction

  function automatic logic [VEC_W-1:0] vec3(input logic [COMP_BITS-1:0] c0, c1, c2);
    return {c2, c1, c0};
  endfunction

  // Tame entries stay within plus or minus one so that most results are in range.
  function automatic logic [ROT_BITS-1:0] rand_rot_entry(input bit wild);
    if (wild) return ROT_BITS'($urandom);
    case ($urandom_range(3))
      0:       return ROT_ONE[ROT_BITS-1:0];
      1:       return -ROT_ONE[ROT_BITS-1:0];
      2:       return '0;
      default: return ROT_BITS'($urandom_range(2 << ROT_FRAC_BITS) - (1 << ROT_FRAC_BITS));
    endcase
  endfunction

  function automatic logic [COMP_BITS-1:0] rand_comp(input bit wild);
    if (wild) return COMP_BITS'($urandom);
    return COMP_BITS'($urandom_range(1 << 15) - (1 << 14));
  endfunction

  function automatic logic [ROW_W-1:0] rand_row(input bit wild);
    return row3(rand_rot_entry(wild), rand_rot_entry(wild), rand_rot_entry(wild));
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec(input bit wild);
    return vec3(rand_comp(wild), rand_comp(wild), rand_comp(wild));
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    bit      wild_pose;
    wild_pose     = ($urandom_range(99) < 20);
    s.pose_row_0  = rand_row(wild_pose);
    s.pose_row_1  = rand_row(wild_pose);
    s.pose_row_2  = rand_row(wild_pose);
    s.meas_force  = rand_vec($urandom_range(99) < 25);
    s.meas_torque = rand_vec($urandom_range(99) < 25);
    return s;
  endfunction

  // ---------------------------------------------------------------- bus and stream drivers

  task automatic apb_access(input reg_idx_e idx, input bit is_write,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= CFG_ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register, mirrors the masked value and reads it back.
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] rdata;
    apb_access(idx, 1'b1, value, rdata);
    register_writes++;
    case (idx)
      REG_MOUNT_ROW_0:   model_cfg.mount_row[0]  = value[ROW_W-1:0];
      REG_MOUNT_ROW_1:   model_cfg.mount_row[1]  = value[ROW_W-1:0];
      REG_MOUNT_ROW_2:   model_cfg.mount_row[2]  = value[ROW_W-1:0];
      REG_GRAVITY_FORCE: model_cfg.gravity_force = value[VEC_W-1:0];
      REG_MASS_CENTER:   model_cfg.mass_center   = value[ROW_W-1:0];
      REG_FORCE_OFFSET:  model_cfg.force_offset  = value[VEC_W-1:0];
      REG_TORQUE_OFFSET: model_cfg.torque_offset = value[VEC_W-1:0];
      default:           model_cfg.enable        = value[0];
    endcase
    check_reg(idx);
  endtask

  task automatic check_reg(input reg_idx_e idx);
    logic [CFG_DATA_W-1:0] rdata;
    apb_access(idx, 1'b0, '0, rdata);
    if (rdata !== shadow_reg(idx)) begin
      errors++;
      $display("%0t: read-back of %s: expected %h, actual %h",
               $time, idx.name(), shadow_reg(idx), rdata);
    end
  endtask

  task automatic send_sample(input sample_t s);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk);
      if ($urandom_range(99) < sender_idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        pose_row_0_i      <= s.pose_row_0;
        pose_row_1_i      <= s.pose_row_1;
        pose_row_2_i      <= s.pose_row_2;
        measured_force_i  <= s.meas_force;
        measured_torque_i <= s.meas_torque;
        in_valid_i        <= 1'b1;
        placed = 1'b1;
      end
    end
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    expected_compensation = {expected_compensation, predict_compensation(s)};
    samples_sent++;
  endtask

  // Holds the input back until every pending word is out and the pipeline has emptied.
  task automatic wait_drained();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (expected_compensation.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- result checking

  task automatic report_mismatch(input string what, input logic [CFG_DATA_W-1:0] expv, actv);
    errors++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, expv, actv);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_compensation.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: force %h, torque %h, saturated %b",
                 $time, corrected_force_o, corrected_torque_o, saturated_o);
      end else begin
        want = expected_compensation.pop_front();
        results_checked++;
        if (corrected_force_o !== want.corr_force)
          report_mismatch("corrected_force", want.corr_force, corrected_force_o);
        if (corrected_torque_o !== want.corr_torque)
          report_mismatch("corrected_torque", want.corr_torque, corrected_torque_o);
        if (saturated_o !== want.saturated)
          report_mismatch("saturated", want.saturated, saturated_o);
      end
    end
  end

  always @(negedge clk) out_stall_i <= ($urandom_range(99) < sink_stall_pct);

  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words outstanding",
               $time, WATCHDOG_LIMIT, expected_compensation.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    reg_idx_e idx;
    idx = idx.first();
    do begin
      check_reg(idx);
      idx = idx.next();
    end while (idx != idx.first());
    // Compensation is off after reset, so both words come straight through.
    send_sample('1);
    send_sample('0);
  endtask

  task automatic test_register_masking();
    reg_idx_e idx;
    wait_drained();
    idx = idx.first();
    do begin
      write_reg(idx, '1);
      idx = idx.next();
    end while (idx != idx.first());
    send_sample('1);
    send_sample('{'0, '0, '0, {3{COMP_MAX}}, {3{COMP_MIN}}});
    wait_drained();
    idx = idx.first();
    do begin
      write_reg(idx, (idx == REG_ENABLE) ? '1 : '0);
      idx = idx.next();
    end while (idx != idx.first());
    send_sample('{'1, '1, '1, vec3(COMP_MAX, COMP_MIN, '0), vec3(COMP_MIN, COMP_MAX, 20'd1)});
    send_sample('{ROW_X, ROW_Y, ROW_Z, '1, '0});
  endtask

  task automatic test_offsets();
    wait_drained();
    write_reg(REG_MOUNT_ROW_0, ROW_X);
    write_reg(REG_MOUNT_ROW_1, ROW_Y);
    write_reg(REG_MOUNT_ROW_2, ROW_Z);
    write_reg(REG_FORCE_OFFSET, vec3('1, 20'd1, '0));
    write_reg(REG_TORQUE_OFFSET, vec3(20'd1, '1, '0));
    // Clamps in both directions on force and torque.
    send_sample('{ROW_X, ROW_Y, ROW_Z, vec3(COMP_MAX, COMP_MIN, COMP_MAX),
                  vec3(COMP_MIN, COMP_MAX, COMP_MIN)});
    // Lands exactly on the limits without clamping.
    send_sample('{ROW_X, ROW_Y, ROW_Z, vec3(COMP_MAX - 1, COMP_MIN + 1, 20'h12345),
                  vec3(COMP_MIN + 1, COMP_MAX - 1, '0)});
  endtask

  task automatic test_gravity_rotation();
    wait_drained();
    write_reg(REG_FORCE_OFFSET, '0);
    write_reg(REG_TORQUE_OFFSET, '0);
    write_reg(REG_GRAVITY_FORCE, vec3(COMP_MAX, COMP_MIN, 20'd3));
    send_sample('{ROW_X, ROW_Y, ROW_Z, '0, '0});
    send_sample('{{3{ROT_MIN}}, {3{ROT_MIN}}, {3{ROT_MIN}}, '0, '0});
    send_sample('{{3{ROT_MAX}}, {3{ROT_MAX}}, {3{ROT_MAX}}, vec3(20'd5, '1, '0), '0});
    // Negative halves of odd values exercise rounding towards minus infinity.
    send_sample('{row3(-ROT_HALF, '0, '0), row3('0, -ROT_HALF, '0), row3('0, '0, -ROT_HALF),
                  '0, '0});
    wait_drained();
    write_reg(REG_MOUNT_ROW_0, {3{ROT_MAX}});
    write_reg(REG_MOUNT_ROW_1, row3(ROT_MIN, ROT_HALF, '0));
    write_reg(REG_MOUNT_ROW_2, row3('0, -ROT_HALF, ROT_MIN));
    send_sample('{ROW_X, ROW_Y, ROW_Z, vec3(20'd7, COMP_MIN, COMP_MAX), '0});
  endtask

  task automatic test_cross_product();
    wait_drained();
    write_reg(REG_MOUNT_ROW_0, ROW_X);
    write_reg(REG_MOUNT_ROW_1, ROW_Y);
    write_reg(REG_MOUNT_ROW_2, ROW_Z);
    write_reg(REG_GRAVITY_FORCE, '0);
    write_reg(REG_MASS_CENTER, row3(ROT_MIN, ROT_MAX, 18'd1));
    send_sample('{ROW_X, ROW_Y, ROW_Z, vec3(COMP_MAX, COMP_MIN, COMP_MAX), '0});
    send_sample('{ROW_X, ROW_Y, ROW_Z, vec3(COMP_MIN, COMP_MAX, COMP_MIN), '0});
    send_sample('{ROW_X, ROW_Y, ROW_Z, vec3(20'd3, -20'd5, 20'd7), vec3(20'd1, '1, '0)});
    send_sample('{ROW_X, ROW_Y, ROW_Z, vec3(20'd1, 20'd1, 20'd1), vec3(COMP_MAX, COMP_MIN, '0)});
  endtask

  task automatic test_enable_off();
    wait_drained();
    // Only the lowest bit of the word counts, so this turns compensation off.
    write_reg(REG_ENABLE, {{(CFG_DATA_W-1){1'b1}}, 1'b0});
    send_sample('{rand_row(1'b1), rand_row(1'b1), rand_row(1'b1), '1, rand_vec(1'b1)});
  endtask

  task automatic randomize_config(input bit wild, input bit enable_on);
    reg_idx_e              idx;
    logic [CFG_DATA_W-1:0] value;
    wait_drained();
    idx = idx.first();
    do begin
      value = {$urandom, $urandom};
      case (idx)
        REG_MOUNT_ROW_0, REG_MOUNT_ROW_1, REG_MOUNT_ROW_2, REG_MASS_CENTER:
          if (!wild) value[ROW_W-1:0] = rand_row(1'b0);
        REG_ENABLE:
          value[0] = enable_on;
        default:
          if (!wild) value[VEC_W-1:0] = rand_vec(1'b0);
      endcase
      write_reg(idx, value);
      idx = idx.next();
    end while (idx != idx.first());
  endtask

  task automatic test_random_traffic();
    int idle_plan[RANDOM_PHASES]  = '{0, 66, 0, 15, 15, 0};
    int stall_plan[RANDOM_PHASES] = '{0, 0, 66, 15, 15, 0};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      randomize_config(p == RANDOM_PHASES - 1, p != 4);
      sender_idle_pct = idle_plan[p];
      sink_stall_pct  = stall_plan[p];
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (p == 3 && i == PHASE_SAMPLES / 2) wait_drained();
        send_sample(rand_sample());
      end
    end
  endtask

  task automatic finish_run();
    sender_idle_pct = 0;
    wait_drained();
    repeat (10) @(negedge clk);
    if (expected_compensation.size() != 0) begin
      errors++;
      $display("%0t: %0d words never arrived", $time, expected_compensation.size());
    end
    $display("Checked %0d of %0d samples over %0d register writes with read-back:",
             results_checked, samples_sent, register_writes);
    $display("pass-through, offsets, rotations, lever-arm torque and clamping, under stalls.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_valid_i        = 1'b0;
    pose_row_0_i      = '0;
    pose_row_1_i      = '0;
    pose_row_2_i      = '0;
    measured_force_i  = '0;
    measured_torque_i = '0;
    out_stall_i       = 1'b0;
    sender_idle_pct   = 0;
    sink_stall_pct    = 0;
    errors            = 0;
    samples_sent      = 0;
    results_checked   = 0;
    register_writes   = 0;
    quiet_cycles      = 0;
    model_cfg              = '0;
    model_cfg.mount_row[0] = ROW_X;
    model_cfg.mount_row[1] = ROW_Y;
    model_cfg.mount_row[2] = ROW_Z;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    test_reset_state();
    test_register_masking();
    test_offsets();
    test_gravity_rotation();
    test_cross_product();
    test_enable_off();
    test_random_traffic();
    finish_run();
  end

endmodule
